### hdl/calendar_slot_scheduler_assert.svh
// Assertion macros used by the calendar slot scheduler sequencer.
`ifndef CALENDAR_SLOT_SCHEDULER_ASSERT_SVH
`define CALENDAR_SLOT_SCHEDULER_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define CSS_CHECK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CSS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/css_pkg.sv
// Shared types and constants of the calendar slot scheduler.
package css_pkg;

    localparam int LOOKAHEAD_DAYS = 7;
    localparam int IDX_W          = $clog2(LOOKAHEAD_DAYS + 1);

    localparam logic [2:0] DEC_NONE      = 3'd0;
    localparam logic [2:0] DEC_FIRE      = 3'd1;
    localparam logic [2:0] DEC_MISSED    = 3'd2;
    localparam logic [2:0] DEC_NO_RESULT = 3'd3;
    localparam logic [2:0] DEC_SKIPPED   = 3'd4;

    localparam logic [1:0] OP_TIME    = 2'd0;
    localparam logic [1:0] OP_RESULT  = 2'd1;
    localparam logic [1:0] OP_RESTORE = 2'd2;

    localparam logic [2:0] CFG_DAY_MASK    = 3'd0;
    localparam logic [2:0] CFG_SLOT_HOUR   = 3'd1;
    localparam logic [2:0] CFG_SLOT_MINUTE = 3'd2;
    localparam logic [2:0] CFG_GRACE       = 3'd3;
    localparam logic [2:0] CFG_NO_TIME     = 3'd4;
    localparam logic [2:0] CFG_RESULT_TO   = 3'd5;
    localparam logic [2:0] CFG_RETRY_HOLD  = 3'd6;

    // Reciprocals: k/10000 = (k*KEY_RECIP)>>40, x/100 = (x*5243)>>19, x/7 = (x*W7_RECIP)>>25
    localparam logic [26:0] KEY_RECIP = 27'd109951163;
    localparam logic [26:0] HUND_RECIP = 27'd5243;
    localparam logic [26:0] W7_RECIP  = 27'd4793491;

    typedef struct packed {
        logic [6:0]  day_mask;
        logic [4:0]  slot_hour;
        logic [5:0]  slot_minute;
        logic [15:0] grace_minutes;
        logic [31:0] no_time_report_ms;
        logic [31:0] result_timeout_ms;
        logic [31:0] retry_hold_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        time_valid;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [31:0] uptime_ms;
        logic        result_ok;
        logic [26:0] restore_key;
    } item_t;

    typedef struct packed {
        logic [2:0]  decision;
        logic        result_accepted;
        logic [15:0] late_minutes;
        logic [7:0]  attempt_count;
        logic [26:0] next_slot_key;
        logic [26:0] last_slot_key;
    } res_t;

endpackage

### hdl/css_mul.sv
// Shared registered multiplier used by the scheduler sequencer.
module css_mul (
    input  logic        aclk,
    input  logic [26:0] a,
    input  logic [26:0] b,
    output logic [53:0] p
);

    logic [53:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### hdl/css_seq.sv
// Sequencer: date checks, weekday, booking decisions and lookahead walk.
`include "calendar_slot_scheduler_assert.svh"

module css_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  css_pkg::item_t  in_item,
    input  css_pkg::cfg_t   cfg,
    output logic            res_valid,
    output css_pkg::res_t   res,
    input  logic            res_free
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_OP1   = 5'd1;
    localparam logic [4:0] ST_R1    = 5'd2;
    localparam logic [4:0] ST_R2    = 5'd3;
    localparam logic [4:0] ST_R3    = 5'd4;
    localparam logic [4:0] ST_R4    = 5'd5;
    localparam logic [4:0] ST_R5    = 5'd6;
    localparam logic [4:0] ST_YQ    = 5'd7;
    localparam logic [4:0] ST_YQ100 = 5'd8;
    localparam logic [4:0] ST_LEAP  = 5'd9;
    localparam logic [4:0] ST_RFIN  = 5'd10;
    localparam logic [4:0] ST_YYQ   = 5'd11;
    localparam logic [4:0] ST_Y365  = 5'd12;
    localparam logic [4:0] ST_SUMN  = 5'd13;
    localparam logic [4:0] ST_W     = 5'd14;
    localparam logic [4:0] ST_W7    = 5'd15;
    localparam logic [4:0] ST_WCHK  = 5'd16;
    localparam logic [4:0] ST_KEY   = 5'd17;
    localparam logic [4:0] ST_K2    = 5'd18;
    localparam logic [4:0] ST_DEC   = 5'd19;
    localparam logic [4:0] ST_LOOK  = 5'd20;
    localparam logic [4:0] ST_OUT   = 5'd21;

    localparam int IW = css_pkg::IDX_W;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the month in a March-based year.
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] c;
        case (mp)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd61;
            4'd3:    c = 9'd92;
            4'd4:    c = 9'd122;
            4'd5:    c = 9'd153;
            4'd6:    c = 9'd184;
            4'd7:    c = 9'd214;
            4'd8:    c = 9'd245;
            4'd9:    c = 9'd275;
            4'd10:   c = 9'd306;
            4'd11:   c = 9'd337;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    // Sequencer and item registers
    logic [4:0]  state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic        tv_reg, tv_next;
    logic [4:0]  hr_reg, hr_next;
    logic [5:0]  mi_reg, mi_next;
    logic [5:0]  se_reg, se_next;
    logic [2:0]  wk_reg, wk_next;
    logic [31:0] up_reg, up_next;
    logic        ok_reg, ok_next;
    logic [26:0] rkey_reg, rkey_next;
    logic [13:0] wy_reg, wy_next;
    logic [6:0]  wm_reg, wm_next;
    logic [6:0]  wdd_reg, wdd_next;
    logic [13:0] rem_reg, rem_next;
    logic [7:0]  yq_reg, yq_next;
    logic [7:0]  yyq_reg, yyq_next;
    logic        leap_reg, leap_next;
    logic        dok_reg, dok_next;
    logic [22:0] n3_reg, n3_next;
    logic        wmatch_reg, wmatch_next;
    logic [26:0] key_reg, key_next;
    logic [26:0] cur_key_reg, cur_key_next;
    logic [3:0]  cur_m_reg, cur_m_next;
    logic [4:0]  cur_d_reg, cur_d_next;
    logic [2:0]  cur_wd_reg, cur_wd_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [26:0] k2_reg, k2_next;
    logic [2:0]  dec_reg, dec_next;
    logic        acc_reg, acc_next;
    logic [26:0] nkey_reg, nkey_next;

    // Scheduler state
    logic [26:0] booked_reg, booked_next;
    logic [26:0] att_reg, att_next;
    logic [26:0] missed_reg, missed_next;
    logic        pending_reg, pending_next;
    logic        bflag_reg, bflag_next;
    logic        hold_reg, hold_next;
    logic [31:0] hs_reg, hs_next;
    logic [31:0] ast_reg, ast_next;
    logic [7:0]  attempts_reg, attempts_next;
    logic [15:0] late_reg, late_next;
    logic        ntr_reg, ntr_next;

    logic [26:0] mul_a, mul_b;
    logic [53:0] p;

    css_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (p)
    );

    logic [13:0] yy;
    logic [3:0]  mp;
    logic [10:0] now_min, slot_min;
    logic [16:0] win_end;
    logic        in_window, sched_en, usable;
    logic [7:0]  mask8;
    logic [4:0]  cur_len;
    logic [26:0] adv_key;
    logic [3:0]  adv_m;
    logic [4:0]  adv_d;
    logic [13:0] rem_calc, dd_calc;
    logic        y100_zero, leap_calc;
    logic [4:0]  wlen;

    assign yy       = wy_reg - {13'd0, (wm_reg <= 7'd2)};
    assign mp       = (wm_reg >= 7'd3) ? (wm_reg[3:0] - 4'd3) : (wm_reg[3:0] + 4'd9);
    assign now_min  = 11'({hr_reg, 6'd0}) - 11'({hr_reg, 2'd0}) + 11'(mi_reg);
    assign slot_min = 11'({cfg.slot_hour, 6'd0}) - 11'({cfg.slot_hour, 2'd0})
                    + 11'(cfg.slot_minute);
    assign win_end  = 17'(slot_min) + 17'(cfg.grace_minutes);
    assign in_window = (now_min >= slot_min) && (17'(now_min) < win_end);
    assign sched_en = (cfg.day_mask != 7'd0) && (cfg.slot_hour <= 5'd23)
                    && (cfg.slot_minute <= 6'd59);
    assign mask8    = {1'b0, cfg.day_mask};
    assign usable   = tv_reg && dok_reg && (hr_reg <= 5'd23) && (mi_reg <= 6'd59)
                    && (se_reg <= 6'd60) && wmatch_reg;

    // One-day step of the cursor; a walk of at most eight days meets February
    // only within today's year, so today's leap flag serves.
    always_comb begin
        cur_len = month_len(cur_m_reg, leap_reg);
        if (cur_d_reg < cur_len) begin
            adv_key = cur_key_reg + 27'd1;
            adv_m   = cur_m_reg;
            adv_d   = cur_d_reg + 5'd1;
        end else if (cur_m_reg != 4'd12) begin
            adv_key = cur_key_reg + 27'd101 - 27'(cur_d_reg);
            adv_m   = cur_m_reg + 4'd1;
            adv_d   = 5'd1;
        end else begin
            adv_key = cur_key_reg + 27'd8870;
            adv_m   = 4'd1;
            adv_d   = 5'd1;
        end
    end

    assign rem_calc  = rkey_reg[13:0] - p[13:0];
    assign dd_calc   = rem_reg - p[13:0];
    assign y100_zero = (p[13:0] == wy_reg);
    assign leap_calc = ((wy_reg[1:0] == 2'd0) && !y100_zero)
                     || (y100_zero && (yq_reg[1:0] == 2'd0));
    assign wlen      = month_len(wm_reg[3:0], leap_calc);

    always_comb begin
        logic        timeout, held, missed_c, fire_c, hit;
        logic [26:0] booked_eff;
        logic [7:0]  att_base;

        state_next = state_reg;
        op_next = op_reg; tv_next = tv_reg; hr_next = hr_reg; mi_next = mi_reg;
        se_next = se_reg; wk_next = wk_reg; up_next = up_reg; ok_next = ok_reg;
        rkey_next = rkey_reg; wy_next = wy_reg; wm_next = wm_reg; wdd_next = wdd_reg;
        rem_next = rem_reg; yq_next = yq_reg; yyq_next = yyq_reg; leap_next = leap_reg;
        dok_next = dok_reg; n3_next = n3_reg; wmatch_next = wmatch_reg; key_next = key_reg;
        cur_key_next = cur_key_reg; cur_m_next = cur_m_reg; cur_d_next = cur_d_reg;
        cur_wd_next = cur_wd_reg; idx_next = idx_reg; k2_next = k2_reg;
        dec_next = dec_reg; acc_next = acc_reg; nkey_next = nkey_reg;
        booked_next = booked_reg; att_next = att_reg; missed_next = missed_reg;
        pending_next = pending_reg; bflag_next = bflag_reg; hold_next = hold_reg;
        hs_next = hs_reg; ast_next = ast_reg; attempts_next = attempts_reg;
        late_next = late_reg; ntr_next = ntr_reg;
        mul_a = 27'd0;
        mul_b = 27'd0;
        timeout = 1'b0; held = 1'b0; missed_c = 1'b0; fire_c = 1'b0; hit = 1'b0;
        booked_eff = booked_reg;
        att_base = attempts_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next   = in_item.op;
                    tv_next   = in_item.time_valid;
                    hr_next   = in_item.hour;
                    mi_next   = in_item.minute;
                    se_next   = in_item.second;
                    wk_next   = in_item.weekday;
                    up_next   = in_item.uptime_ms;
                    ok_next   = in_item.result_ok;
                    rkey_next = in_item.restore_key;
                    wy_next   = in_item.year;
                    wm_next   = 7'(in_item.month);
                    wdd_next  = 7'(in_item.day_of_month);
                    dec_next  = css_pkg::DEC_NONE;
                    acc_next  = 1'b0;
                    nkey_next = 27'd0;
                    case (in_item.op)
                        css_pkg::OP_TIME:    state_next = ST_YQ;
                        css_pkg::OP_RESULT:  state_next = ST_OP1;
                        css_pkg::OP_RESTORE: state_next = ST_R1;
                        default:             state_next = ST_OUT;
                    endcase
                end
            end
            ST_OP1: begin
                if (pending_reg) begin
                    pending_next = 1'b0;
                    if (!ok_reg) begin
                        hold_next = 1'b1;
                        hs_next   = up_reg;
                    end else begin
                        booked_next = att_reg;
                        bflag_next  = 1'b1;
                        acc_next    = 1'b1;
                    end
                end
                state_next = ST_OUT;
            end
            ST_R1: begin
                mul_a = rkey_reg;
                mul_b = css_pkg::KEY_RECIP;
                state_next = ST_R2;
            end
            ST_R2: begin
                wy_next = p[53:40];
                mul_a = 27'(p[53:40]);
                mul_b = 27'd10000;
                state_next = ST_R3;
            end
            ST_R3: begin
                rem_next = rem_calc;
                mul_a = 27'(rem_calc);
                mul_b = css_pkg::HUND_RECIP;
                state_next = ST_R4;
            end
            ST_R4: begin
                wm_next = p[25:19];
                mul_a = 27'(p[25:19]);
                mul_b = 27'd100;
                state_next = ST_R5;
            end
            ST_R5: begin
                wdd_next = dd_calc[6:0];
                state_next = ST_YQ;
            end
            ST_YQ: begin
                mul_a = 27'(wy_reg);
                mul_b = css_pkg::HUND_RECIP;
                state_next = ST_YQ100;
            end
            ST_YQ100: begin
                yq_next = p[26:19];
                mul_a = 27'(p[26:19]);
                mul_b = 27'd100;
                state_next = ST_LEAP;
            end
            ST_LEAP: begin
                leap_next = leap_calc;
                dok_next  = (wy_reg >= 14'd2000) && (wy_reg <= 14'd9999)
                          && (wm_reg >= 7'd1) && (wm_reg <= 7'd12)
                          && (wdd_reg >= 7'd1) && (wdd_reg <= 7'(wlen));
                state_next = (op_reg == css_pkg::OP_RESTORE) ? ST_RFIN : ST_YYQ;
            end
            ST_RFIN: begin
                booked_next = dok_reg ? rkey_reg : 27'd0;
                state_next = ST_OUT;
            end
            ST_YYQ: begin
                mul_a = 27'(yy);
                mul_b = css_pkg::HUND_RECIP;
                state_next = ST_Y365;
            end
            ST_Y365: begin
                yyq_next = p[26:19];
                mul_a = 27'(yy);
                mul_b = 27'd365;
                state_next = ST_SUMN;
            end
            ST_SUMN: begin
                // day count since 0000-03-01 plus three: weekday = this mod 7
                n3_next = p[22:0] + 23'(yy[13:2]) - 23'(yyq_reg) + 23'(yyq_reg[7:2])
                        + 23'(cum_days(mp)) + 23'(wdd_reg) + 23'd2;
                state_next = ST_W;
            end
            ST_W: begin
                mul_a = 27'(n3_reg);
                mul_b = css_pkg::W7_RECIP;
                state_next = ST_W7;
            end
            ST_W7: begin
                mul_a = 27'(p[47:25]);
                mul_b = 27'd7;
                state_next = ST_WCHK;
            end
            ST_WCHK: begin
                wmatch_next = ((n3_reg[2:0] - p[2:0]) == wk_reg);
                mul_a = 27'(wy_reg);
                mul_b = 27'd10000;
                state_next = ST_KEY;
            end
            ST_KEY: begin
                key_next = p[26:0] + 27'({wm_reg, 6'd0}) + 27'({wm_reg, 5'd0})
                         + 27'({wm_reg, 2'd0}) + 27'(wdd_reg);
                cur_key_next = p[26:0] + 27'({wm_reg, 6'd0}) + 27'({wm_reg, 5'd0})
                             + 27'({wm_reg, 2'd0}) + 27'(wdd_reg);
                cur_m_next = wm_reg[3:0];
                cur_d_next = wdd_reg[4:0];
                idx_next   = '0;
                state_next = ST_K2;
            end
            ST_K2: begin
                cur_key_next = adv_key;
                cur_m_next   = adv_m;
                cur_d_next   = adv_d;
                idx_next     = idx_reg + IW'(1);
                if (idx_reg == IW'(1)) begin
                    k2_next    = adv_key;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (!usable) begin
                    if (sched_en && !ntr_reg && (up_reg > cfg.no_time_report_ms)) begin
                        ntr_next = 1'b1;
                        dec_next = css_pkg::DEC_SKIPPED;
                    end
                    state_next = ST_OUT;
                end else begin
                    timeout = pending_reg && ((up_reg - ast_reg) >= cfg.result_timeout_ms);
                    if (timeout) begin
                        pending_next = 1'b0;
                        hold_next    = 1'b1;
                        hs_next      = up_reg;
                        dec_next     = css_pkg::DEC_NO_RESULT;
                    end else begin
                        // booked date more than two days ahead is dropped
                        if (booked_reg != 27'd0 && booked_reg > k2_reg) begin
                            booked_eff = 27'd0;
                        end
                        booked_next = booked_eff;
                        held = hold_reg && ((up_reg - hs_reg) < cfg.retry_hold_ms);
                        missed_c = !pending_reg && att_reg != 27'd0 && !bflag_reg
                                 && missed_reg != att_reg
                                 && (key_reg != att_reg || !in_window);
                        fire_c = sched_en && mask8[wk_reg] && key_reg > booked_eff
                               && in_window && !pending_reg && !held;
                        if (missed_c) begin
                            missed_next = att_reg;
                            dec_next    = css_pkg::DEC_MISSED;
                        end else if (fire_c) begin
                            hold_next = 1'b0;
                            att_base  = (key_reg != att_reg) ? 8'd0 : attempts_reg;
                            attempts_next = (att_base == 8'd255) ? 8'd255 : att_base + 8'd1;
                            att_next     = key_reg;
                            bflag_next   = 1'b0;
                            pending_next = 1'b1;
                            ast_next     = up_reg;
                            late_next    = 16'(now_min - slot_min);
                            dec_next     = css_pkg::DEC_FIRE;
                        end
                    end
                    cur_key_next = key_reg;
                    cur_m_next   = wm_reg[3:0];
                    cur_d_next   = wdd_reg[4:0];
                    cur_wd_next  = wk_reg;
                    idx_next     = '0;
                    state_next   = sched_en ? ST_LOOK : ST_OUT;
                end
            end
            ST_LOOK: begin
                hit = mask8[cur_wd_reg] && (cur_key_reg > booked_reg)
                    && !(idx_reg == '0 && 17'(now_min) >= win_end);
                if (hit) begin
                    nkey_next  = cur_key_reg;
                    state_next = ST_OUT;
                end else if (idx_reg == IW'(css_pkg::LOOKAHEAD_DAYS)) begin
                    state_next = ST_OUT;
                end else begin
                    cur_key_next = adv_key;
                    cur_m_next   = adv_m;
                    cur_d_next   = adv_d;
                    cur_wd_next  = (cur_wd_reg == 3'd6) ? 3'd0 : cur_wd_reg + 3'd1;
                    idx_next     = idx_reg + IW'(1);
                end
            end
            ST_OUT: begin
                if (res_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            booked_reg   <= 27'd0;
            att_reg      <= 27'd0;
            missed_reg   <= 27'd0;
            pending_reg  <= 1'b0;
            bflag_reg    <= 1'b0;
            hold_reg     <= 1'b0;
            hs_reg       <= 32'd0;
            ast_reg      <= 32'd0;
            attempts_reg <= 8'd0;
            late_reg     <= 16'd0;
            ntr_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            booked_reg   <= booked_next;
            att_reg      <= att_next;
            missed_reg   <= missed_next;
            pending_reg  <= pending_next;
            bflag_reg    <= bflag_next;
            hold_reg     <= hold_next;
            hs_reg       <= hs_next;
            ast_reg      <= ast_next;
            attempts_reg <= attempts_next;
            late_reg     <= late_next;
            ntr_reg      <= ntr_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; tv_reg <= tv_next; hr_reg <= hr_next; mi_reg <= mi_next;
        se_reg <= se_next; wk_reg <= wk_next; up_reg <= up_next; ok_reg <= ok_next;
        rkey_reg <= rkey_next; wy_reg <= wy_next; wm_reg <= wm_next; wdd_reg <= wdd_next;
        rem_reg <= rem_next; yq_reg <= yq_next; yyq_reg <= yyq_next;
        leap_reg <= leap_next; dok_reg <= dok_next; n3_reg <= n3_next;
        wmatch_reg <= wmatch_next; key_reg <= key_next; cur_key_reg <= cur_key_next;
        cur_m_reg <= cur_m_next; cur_d_reg <= cur_d_next; cur_wd_reg <= cur_wd_next;
        k2_reg <= k2_next; dec_reg <= dec_next; acc_reg <= acc_next;
        nkey_reg <= nkey_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res = '{decision:        dec_reg,
                   result_accepted: acc_reg,
                   late_minutes:    late_reg,
                   attempt_count:   attempts_reg,
                   next_slot_key:   nkey_reg,
                   last_slot_key:   booked_reg};

    `CSS_CHECK(a_fire_pending, (res_valid && res.decision == css_pkg::DEC_FIRE) |-> pending_reg, "fire without pending attempt")
    `CSS_CHECK(a_fire_count, (res_valid && res.decision == css_pkg::DEC_FIRE) |-> (attempts_reg != 8'd0), "fire with zero attempt count")
    `CSS_CHECK(a_idx_range, idx_reg <= IW'(css_pkg::LOOKAHEAD_DAYS), "lookahead index out of range")
    `CSS_CHECK_NEXT(a_accept_busy, in_valid && in_ready, state_reg != ST_IDLE, "accepted transaction left sequencer idle")

endmodule

### hdl/calendar_slot_scheduler.sv
// Top level of the weekday calendar slot scheduler.
//
// Usage:
//   s_ channel: one transaction per item; s_tuser carries the op (time sample,
//     result report, restore of the last booked date), s_tdata the fields.
//   m_ channel: exactly one result transaction per input transaction, in order.
//   cfg_ channel: register writes, always ready; write only while idle.
// Throughput: one item at a time; the sequencer takes no new transaction until
//   it has handed on its result. The cost of an item is the chain of multiplies
//   through the one shared multiplier (date checks, weekday, date key) plus the
//   day-by-day lookahead walk of up to eight days.
// The next item is taken as soon as the sequencer has handed its result to
//   the output register, even while that result still waits on m_tready.
// A stalled receiver holds the output register and, once the sequencer has a
//   further result, holds the sequencer too (s_tready stays low).
// Reset (aresetn low, synchronous): control and configuration registers to their
//   defaults, all booking state cleared, no result pending.
module calendar_slot_scheduler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // time_valid, year, month, day_of_month, hour, minute, second, weekday,
    // uptime_ms, result_ok, restore_key
    input  logic [103:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_accepted, late_minutes, attempt_count, next_slot_key,
    // last_slot_key, one zero pad bit
    output logic [79:0]  m_tdata,
    // decision
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    css_pkg::cfg_t  cfg_reg, cfg_next;
    css_pkg::item_t item;
    css_pkg::res_t  res, out_reg, out_next;
    logic           res_valid, res_free;
    logic           m_tvalid_reg, m_tvalid_next;

    // Unpack the slave transaction, lowest field first.
    assign item = '{op:           s_tuser,
                    time_valid:   s_tdata[0],
                    year:         s_tdata[14:1],
                    month:        s_tdata[18:15],
                    day_of_month: s_tdata[23:19],
                    hour:         s_tdata[28:24],
                    minute:       s_tdata[34:29],
                    second:       s_tdata[40:35],
                    weekday:      s_tdata[43:41],
                    uptime_ms:    s_tdata[75:44],
                    result_ok:    s_tdata[76],
                    restore_key:  s_tdata[103:77]};

    // Configuration registers; a zero grace is held as one minute.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                css_pkg::CFG_DAY_MASK:    cfg_next.day_mask    = cfg_data[6:0];
                css_pkg::CFG_SLOT_HOUR:   cfg_next.slot_hour   = cfg_data[4:0];
                css_pkg::CFG_SLOT_MINUTE: cfg_next.slot_minute = cfg_data[5:0];
                css_pkg::CFG_GRACE: begin
                    cfg_next.grace_minutes = (cfg_data[15:0] == 16'd0) ? 16'd1
                                                                       : cfg_data[15:0];
                end
                css_pkg::CFG_NO_TIME:     cfg_next.no_time_report_ms = cfg_data;
                css_pkg::CFG_RESULT_TO:   cfg_next.result_timeout_ms = cfg_data;
                css_pkg::CFG_RETRY_HOLD:  cfg_next.retry_hold_ms     = cfg_data;
                default: ;
            endcase
        end
    end

    css_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (item),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free)
    );

    // Output register: frees the sequencer while a result waits on m_tready.
    assign res_free = !m_tvalid_reg || m_tready;

    always_comb begin
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_free) begin
            out_next      = res;
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cfg_reg <= '{day_mask:          7'd0,
                         slot_hour:         5'd0,
                         slot_minute:       6'd0,
                         grace_minutes:     16'd1,
                         no_time_report_ms: 32'd600000,
                         result_timeout_ms: 32'd60000,
                         retry_hold_ms:     32'd300000};
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            cfg_reg      <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = out_reg.decision;
    assign m_tdata   = {1'b0, out_reg.last_slot_key, out_reg.next_slot_key,
                        out_reg.attempt_count, out_reg.late_minutes,
                        out_reg.result_accepted};

endmodule
